// ===== src/bounded_list_insert_delete_member_top_defines.svh =====
// Assertion macros for the bounded list RTL.
`ifndef BOUNDED_LIST_INSERT_DELETE_MEMBER_TOP_DEFINES_SVH
`define BOUNDED_LIST_INSERT_DELETE_MEMBER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BLIST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded list check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BLIST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded list check failed");

`endif

// ===== src/blist_pkg.sv =====
// Package with the sizes, codes and cell command type of the bounded list.
package blist_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 8;

  // Count width must hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int FILL_W = 4;
  localparam int VAL_W = 32;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Request codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_MEMBER = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
    logic                    insert_en;
    logic                    delete_en;
  } cell_cmd_t;

endpackage

// ===== src/blist_cell.sv =====
// One storage cell of the list: holds an entry, compares it and shifts it.
module blist_cell (
  input  logic                              clk,
  input  logic [blist_pkg::CNT_W-1:0]       idx,
  input  blist_pkg::cell_cmd_t              cmd,
  input  logic                              hit_in,
  input  logic signed [blist_pkg::VAL_W-1:0] next_entry,
  output logic                              hit_out,
  output logic signed [blist_pkg::VAL_W-1:0] entry
);
  import blist_pkg::*;

  logic live;
  logic match;

  // Only cells below the fill count take part in the search.
  assign live    = idx < cmd.count;
  assign match   = live && (entry == cmd.value);
  // The hit travels up the row: set from the first match onward.
  assign hit_out = hit_in | match;

  // Append lands in the first free cell; delete pulls the upper neighbor down
  // into every cell at or above the first match.
  always_ff @(posedge clk) begin
    if (cmd.insert_en && (idx == cmd.count)) begin
      entry <= cmd.value;
    end else if (cmd.delete_en && hit_out) begin
      entry <= next_entry;
    end
  end

endmodule

// ===== src/bounded_list_insert_delete_member_top.sv =====
// The result of an item is registered and shows in the cycle after acceptance.
// Throughput: one item per cycle while the output is not stalled, limited by the match chain across the cell row.
// Every cell compares in parallel; the first-match flag ripples through CAPACITY cells.
// Reset clears the fill count and the output valid; stored entries keep their contents.
// An output register lets a new item in while the previous result is taken.
`include "bounded_list_insert_delete_member_top_defines.svh"

module bounded_list_insert_delete_member_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         opcode,
  input  logic signed [blist_pkg::VAL_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic                               found,
  output logic [blist_pkg::FILL_W-1:0]       fill_count
);
  import blist_pkg::*;

  logic                    accept;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [1:0]              status_next;
  logic                    found_next;
  logic                    present;
  logic                    full;
  logic                    empty;
  cell_cmd_t               cmd;
  logic                    hit [CAPACITY+1];
  logic signed [VAL_W-1:0] ent [CAPACITY];

  // Input is held off only while a result waits and is itself stalled.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CAP_CNT);
  assign empty    = (count == '0);

  // Command broadcast to the cell row.
  always_comb begin
    cmd.value     = value;
    cmd.count     = count;
    cmd.insert_en = accept && (opcode == OP_INSERT) && !full;
    cmd.delete_en = accept && (opcode == OP_DELETE);
  end

  // Row of cells, each linked to its upper neighbor.
  assign hit[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] upper;
    if (i == CAPACITY - 1) begin : g_top
      assign upper = ent[i];
    end else begin : g_mid
      assign upper = ent[i+1];
    end
    blist_cell u_cell (
      .clk        (clk),
      .idx        (CNT_W'(i)),
      .cmd        (cmd),
      .hit_in     (hit[i]),
      .next_entry (upper),
      .hit_out    (hit[i+1]),
      .entry      (ent[i])
    );
  end

  assign present = hit[CAPACITY];

  // Status, found flag and new fill count for the request.
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    found_next  = present;
    unique case (opcode)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (!present) begin
          status_next = ST_NOTFOUND;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      OP_MEMBER: begin
        status_next = present ? ST_OK : ST_NOTFOUND;
      end
      default: begin
        count_next = '0;
        found_next = 1'b0;
      end
    endcase
  end

  // Fill count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      status     <= status_next;
      found      <= found_next;
      fill_count <= FILL_W'(count_next);
    end
  end

  `BLIST_ASSERT_NOW(a_count_bound, 1'b1, count <= CAP_CNT)
  `BLIST_ASSERT_NEXT(a_full_insert, accept && (opcode == OP_INSERT) && full,
                     (status == ST_FULL) && $stable(count))
  `BLIST_ASSERT_NEXT(a_clear, accept && (opcode == OP_CLEAR),
                     (count == '0) && !found && (status == ST_OK))
  `BLIST_ASSERT_NEXT(a_delete_hit, accept && (opcode == OP_DELETE) && present,
                     (status == ST_OK) && (count == $past(count) - CNT_W'(1)))

endmodule
